/* rtl/mlfq_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mlfq_pkg
// shared codes, widths, defaults and control/status bundles of the
// multilevel feedback queue thread scheduler
// ----------------------------------------------------------------------------
package mlfq_pkg;

  // fixed field widths
  localparam int unsigned CMD_W       = 3;
  localparam int unsigned THREAD_ID_W = 8;
  localparam int unsigned RUN_ID_W    = 8;
  localparam int unsigned RUN_LVL_W   = 2;
  localparam int unsigned STATUS_W    = 2;

  // parameter defaults
  localparam int unsigned NUM_LEVELS_DEF  = 4;
  localparam int unsigned QUEUE_DEPTH_DEF = 16;
  localparam int unsigned ID_BITS_DEF     = 8;

  // policy register
  localparam logic POLICY_RR   = 1'b0;
  localparam logic POLICY_MLFQ = 1'b1;

  // command codes
  localparam logic [CMD_W-1:0] CMD_ADD    = 3'd0;
  localparam logic [CMD_W-1:0] CMD_EXPIRE = 3'd1;
  localparam logic [CMD_W-1:0] CMD_YIELD  = 3'd2;
  localparam logic [CMD_W-1:0] CMD_STOP   = 3'd3;
  localparam logic [CMD_W-1:0] CMD_WAKE   = 3'd4;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NOCUR = 2'd2;

  typedef enum logic [1:0] {
    CLS_NONE,
    CLS_PUSH,
    CLS_SCHED
  } cmd_class_e;

  // controller -> datapath
  typedef struct packed {
    logic capture;     // input transfer, latch cmd and id
    logic push_new;    // append latched id to level 0
    logic start_pop;   // read head of scheduled level
    logic flag_empty;  // scheduled level empty
    logic pop;         // remove head of scheduled level
    logic push_moved;  // append popped id to its target level
    logic pick;        // select current level
    logic rd_head;     // read head of current level
    logic load_out;    // load the result register
  } ctrl_cmd_t;

  // datapath -> controller
  typedef struct packed {
    cmd_class_e cls;
    logic       is_stop;
    logic       sched_empty;
    logic       out_free;
  } dp_status_t;

endpackage

/* rtl/mlfq_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mlfq_ctrl
// sequencer that steps one command through queue memory accesses
// ----------------------------------------------------------------------------
module mlfq_ctrl import mlfq_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  dp_status_t dp_status_i,
  output ctrl_cmd_t  dp_cmd_o
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_EXEC  = 3'd1;
  localparam logic [2:0] S_POP   = 3'd2;
  localparam logic [2:0] S_PUSH  = 3'd3;
  localparam logic [2:0] S_PICK  = 3'd4;
  localparam logic [2:0] S_RDREQ = 3'd5;
  localparam logic [2:0] S_OUT   = 3'd6;

  logic [2:0] state_q, state_d;

  always_comb begin
    state_d    = state_q;
    dp_cmd_o   = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          dp_cmd_o.capture = 1'b1;
          state_d          = S_EXEC;
        end
      end
      S_EXEC: begin
        case (dp_status_i.cls)
          CLS_PUSH: begin
            dp_cmd_o.push_new = 1'b1;
            state_d           = S_RDREQ;
          end
          CLS_SCHED: begin
            if (dp_status_i.sched_empty) begin
              dp_cmd_o.flag_empty = 1'b1;
              state_d             = S_PICK;
            end else begin
              dp_cmd_o.start_pop = 1'b1;
              state_d            = S_POP;
            end
          end
          default: state_d = S_RDREQ;
        endcase
      end
      S_POP: begin
        dp_cmd_o.pop = 1'b1;
        state_d      = dp_status_i.is_stop ? S_PICK : S_PUSH;
      end
      S_PUSH: begin
        dp_cmd_o.push_moved = 1'b1;
        state_d             = S_PICK;
      end
      S_PICK: begin
        dp_cmd_o.pick = 1'b1;
        state_d       = S_RDREQ;
      end
      S_RDREQ: begin
        dp_cmd_o.rd_head = 1'b1;
        state_d          = S_OUT;
      end
      S_OUT: begin
        if (dp_status_i.out_free) begin
          dp_cmd_o.load_out = 1'b1;
          state_d           = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

/* rtl/mlfq_dpath.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mlfq_dpath
// level queue memory, head and count registers, level pick and result register
// ----------------------------------------------------------------------------
module mlfq_dpath import mlfq_pkg::*; #(
  parameter int unsigned NUM_LEVELS  = NUM_LEVELS_DEF,
  parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF,
  parameter int unsigned ID_BITS     = ID_BITS_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic                   cfg_wdata_i,
  input  logic [CMD_W-1:0]       cmd_i,
  input  logic [THREAD_ID_W-1:0] thread_id_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic [RUN_ID_W-1:0]    run_id_o,
  output logic [RUN_LVL_W-1:0]   run_level_o,
  output logic                   idle_o,
  output logic [STATUS_W-1:0]    status_o,
  input  ctrl_cmd_t              dp_cmd_i,
  output dp_status_t             dp_status_o
);

  localparam int unsigned LVL_W     = $clog2(NUM_LEVELS);
  localparam int unsigned PTR_W     = $clog2(QUEUE_DEPTH);
  localparam int unsigned CNT_W     = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned MEM_DEPTH = NUM_LEVELS * QUEUE_DEPTH;
  localparam int unsigned ADDR_W    = $clog2(MEM_DEPTH);

  function automatic logic [PTR_W-1:0] tail_pos(input logic [PTR_W-1:0] head,
                                                input logic [CNT_W-1:0] cnt);
    logic [CNT_W:0] sum;
    sum = (CNT_W+1)'(head) + (CNT_W+1)'(cnt);
    if (sum >= (CNT_W+1)'(QUEUE_DEPTH)) begin
      sum = sum - (CNT_W+1)'(QUEUE_DEPTH);
    end
    return sum[PTR_W-1:0];
  endfunction

  function automatic logic [PTR_W-1:0] wrap_inc(input logic [PTR_W-1:0] head);
    logic [PTR_W:0] nxt;
    nxt = (PTR_W+1)'(head) + (PTR_W+1)'(1);
    return (nxt == (PTR_W+1)'(QUEUE_DEPTH)) ? '0 : nxt[PTR_W-1:0];
  endfunction

  function automatic logic [ADDR_W-1:0] slot_addr(input logic [LVL_W-1:0] lvl,
                                                  input logic [PTR_W-1:0] pos);
    return ADDR_W'(lvl) * ADDR_W'(QUEUE_DEPTH) + ADDR_W'(pos);
  endfunction

  // queue storage
  logic [ID_BITS-1:0] mem [MEM_DEPTH];
  logic [ID_BITS-1:0] rd_q;
  logic               mem_we, mem_re;
  logic [ADDR_W-1:0]  mem_waddr, mem_raddr;
  logic [ID_BITS-1:0] mem_wdata;

  logic [CMD_W-1:0]   cmd_q;
  logic [ID_BITS-1:0] tid_q;
  logic               policy_q;
  logic [PTR_W-1:0]   head_q  [NUM_LEVELS];
  logic [PTR_W-1:0]   head_d  [NUM_LEVELS];
  logic [CNT_W-1:0]   count_q [NUM_LEVELS];
  logic [CNT_W-1:0]   count_d [NUM_LEVELS];
  logic [LVL_W-1:0]   cur_q, cur_d;
  logic [STATUS_W-1:0] st_q, st_d;

  logic                 out_valid_q;
  logic [RUN_ID_W-1:0]  run_id_q;
  logic [RUN_LVL_W-1:0] run_level_q;
  logic                 idle_q;
  logic [STATUS_W-1:0]  status_q;

  logic [LVL_W-1:0] sched_lvl, dest_lvl, push_lvl, hi_lvl;
  logic [LVL_W:0]   lvl_inc;
  logic [ID_BITS-1:0] push_data;
  logic             any_busy;
  cmd_class_e       cls;

  always_comb begin
    unique case (cmd_q) inside
      CMD_ADD, CMD_WAKE:              cls = CLS_PUSH;
      CMD_EXPIRE, CMD_YIELD, CMD_STOP: cls = CLS_SCHED;
      default:                        cls = CLS_NONE;
    endcase
  end

  assign sched_lvl = (policy_q == POLICY_MLFQ) ? cur_q : '0;
  assign lvl_inc   = (LVL_W+1)'(sched_lvl) + (LVL_W+1)'(1);

  // demote on expiry in mlfq mode unless already on the last level
  always_comb begin
    dest_lvl = sched_lvl;
    if (cmd_q == CMD_EXPIRE && policy_q == POLICY_MLFQ &&
        lvl_inc < (LVL_W+1)'(NUM_LEVELS)) begin
      dest_lvl = lvl_inc[LVL_W-1:0];
    end
  end

  // lowest-numbered non-empty level, level 0 when all empty
  always_comb begin
    hi_lvl   = '0;
    any_busy = 1'b0;
    for (int l = NUM_LEVELS - 1; l >= 0; l--) begin
      if (count_q[l] != '0) begin
        hi_lvl   = LVL_W'(l);
        any_busy = 1'b1;
      end
    end
  end

  assign push_lvl  = dp_cmd_i.push_new ? '0 : dest_lvl;
  assign push_data = dp_cmd_i.push_new ? tid_q : rd_q;

  always_comb begin
    head_d    = head_q;
    count_d   = count_q;
    cur_d     = cur_q;
    st_d      = st_q;
    mem_we    = 1'b0;
    mem_waddr = '0;
    mem_wdata = push_data;
    mem_re    = 1'b0;
    mem_raddr = '0;

    if (dp_cmd_i.capture) begin
      st_d = ST_OK;
    end
    if (dp_cmd_i.push_new || dp_cmd_i.push_moved) begin
      if (count_q[push_lvl] >= CNT_W'(QUEUE_DEPTH)) begin
        st_d = ST_FULL;
      end else begin
        mem_we            = 1'b1;
        mem_waddr         = slot_addr(push_lvl,
                                      tail_pos(head_q[push_lvl], count_q[push_lvl]));
        count_d[push_lvl] = count_q[push_lvl] + CNT_W'(1);
      end
    end
    if (dp_cmd_i.start_pop) begin
      mem_re    = 1'b1;
      mem_raddr = slot_addr(sched_lvl, head_q[sched_lvl]);
    end
    if (dp_cmd_i.flag_empty) begin
      st_d = ST_NOCUR;
    end
    if (dp_cmd_i.pop) begin
      head_d[sched_lvl]  = wrap_inc(head_q[sched_lvl]);
      count_d[sched_lvl] = count_q[sched_lvl] - CNT_W'(1);
    end
    if (dp_cmd_i.pick) begin
      cur_d = (policy_q == POLICY_MLFQ) ? hi_lvl : '0;
    end
    if (dp_cmd_i.rd_head) begin
      mem_re    = 1'b1;
      mem_raddr = slot_addr(cur_q, head_q[cur_q]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_q <= mem[mem_raddr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int l = 0; l < NUM_LEVELS; l++) begin
        head_q[l]  <= '0;
        count_q[l] <= '0;
      end
      cur_q       <= '0;
      policy_q    <= POLICY_MLFQ;
      st_q        <= ST_OK;
      out_valid_q <= 1'b0;
    end else begin
      head_q  <= head_d;
      count_q <= count_d;
      cur_q   <= cur_d;
      st_q    <= st_d;
      if (cfg_we_i) begin
        policy_q <= cfg_wdata_i;
      end
      if (dp_cmd_i.load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (dp_cmd_i.capture) begin
      cmd_q <= cmd_i;
      tid_q <= ID_BITS'(thread_id_i);
    end
    if (dp_cmd_i.load_out) begin
      if (count_q[cur_q] != '0) begin
        run_id_q    <= RUN_ID_W'(rd_q);
        run_level_q <= RUN_LVL_W'(cur_q);
      end else begin
        run_id_q    <= '0;
        run_level_q <= '0;
      end
      idle_q   <= ~any_busy;
      status_q <= st_q;
    end
  end

  assign dp_status_o.cls         = cls;
  assign dp_status_o.is_stop     = (cmd_q == CMD_STOP);
  assign dp_status_o.sched_empty = (count_q[sched_lvl] == '0);
  assign dp_status_o.out_free    = ~out_valid_q | out_ready_i;

  assign out_valid_o = out_valid_q;
  assign run_id_o    = run_id_q;
  assign run_level_o = run_level_q;
  assign idle_o      = idle_q;
  assign status_o    = status_q;

endmodule

/* rtl/mlfq_thread_scheduler_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mlfq_thread_scheduler_top
// multilevel feedback queue thread scheduler, one result per command
// ----------------------------------------------------------------------------
// Each command transfer on the input channel yields exactly one result
// transfer on the output channel. The block works on one command at a time.
// After the accept and execute states, add, wake and unknown codes go
// straight to the head read; an expiry, yield or stop on an empty level
// first does a level pick, stop a pop read and a level pick, and expiry
// and yield a pop read, a push write and a level pick. These steps come
// from the sequencer stepping through the single-write, single-read queue
// memory (a pop read, a push write, a level pick, then a registered read
// of the new head). A held result register lets the next command be taken
// while the previous result still waits; a new input is accepted once the
// sequencer is back in its idle state, and a result that is still held
// when the next one is ready stalls the sequencer for as long as the
// output is not taken. The policy register resets to multilevel feedback
// and should only be written between commands. There is no clearing pass:
// an unwritten entry is only ever read as the head of an empty level, and
// that read data is dropped.
// ----------------------------------------------------------------------------
module mlfq_thread_scheduler_top import mlfq_pkg::*; #(
  parameter int unsigned NUM_LEVELS  = NUM_LEVELS_DEF,
  parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF,
  parameter int unsigned ID_BITS     = ID_BITS_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // policy register write
  input  logic                   cfg_we_i,
  input  logic                   cfg_wdata_i,
  // command channel
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic [CMD_W-1:0]       cmd_i,
  input  logic [THREAD_ID_W-1:0] thread_id_i,
  // result channel
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic [RUN_ID_W-1:0]    run_id_o,
  output logic [RUN_LVL_W-1:0]   run_level_o,
  output logic                   idle_o,
  output logic [STATUS_W-1:0]    status_o
);

  ctrl_cmd_t  dp_cmd;     // sequencer commands
  dp_status_t dp_status;  // command class, stop flag, empty flag, result slot free

  // sequencer: one state per step of a command
  mlfq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .dp_status_i (dp_status),
    .dp_cmd_o    (dp_cmd)
  );

  // queues, level state and the result register
  mlfq_dpath #(
    .NUM_LEVELS  (NUM_LEVELS),
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .ID_BITS     (ID_BITS)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cmd_i       (cmd_i),
    .thread_id_i (thread_id_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .run_id_o    (run_id_o),
    .run_level_o (run_level_o),
    .idle_o      (idle_o),
    .status_o    (status_o),
    .dp_cmd_i    (dp_cmd),
    .dp_status_o (dp_status)
  );

endmodule
